>>> sv/ftnh_pkg.sv
// Shared constants for the fat-tree next-hop lookup core.
// Field widths, op codes, node roles and configuration register indexes.
// No dependencies.
`default_nettype none

package ftnh_pkg;

  // default sizing of the tables and node ids
  localparam int PORTS_DEF        = 8;
  localparam int NODE_ID_BITS_DEF = 10;

  // fixed field widths
  localparam int OP_W        = 3;
  localparam int IDX_W       = 3;
  localparam int OCTET_W     = 8;
  localparam int ROLE_W      = 2;
  localparam int OUT_NODE_W  = 10;
  localparam int OUT_PORT_W  = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;

  // op codes of an input word
  localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_NBR  = 3'd1;
  localparam logic [OP_W-1:0] OP_WR_CORE = 3'd2;
  localparam logic [OP_W-1:0] OP_WR_PFX  = 3'd3;
  localparam logic [OP_W-1:0] OP_WR_SFX  = 3'd4;

  // node roles
  localparam logic [ROLE_W-1:0] ROLE_HOST = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_CORE = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_EDGE = 2'd2;
  localparam logic [ROLE_W-1:0] ROLE_AGG  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ROLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPLINK    = 1'd1;

endpackage

`default_nettype wire

>>> sv/fat_tree_next_hop_lookup_core.sv
// Next-hop lookup core of one fat-tree node: table memory, match and port search.
// Depends on ftnh_pkg.
//
// Load words fill the port-neighbor, core-route, prefix-route and suffix-route tables;
// a lookup word returns one result word (found, next node, port), other op codes
// return nothing. All tables live in one three-row memory (neighbor row, core row,
// prefix+suffix row) with two registered read ports and one write port, so every
// entry of a table is compared at once. After acceptance a lookup passes the match
// state on the read rows, then the port search of the chosen next hop. The next
// lookup is accepted in the port-search state when the output register is free, so
// it overlaps the last lookup's port search. A load is a read-modify-write of its
// table row; no word is accepted during the write-back.
// Tables are not cleared at reset and must be loaded before they are looked up.
// The user must write configuration only while the core is idle; the core does not enforce it.
`default_nettype none

module fat_tree_next_hop_lookup_core #(
  parameter int PORTS        = ftnh_pkg::PORTS_DEF,
  parameter int NODE_ID_BITS = ftnh_pkg::NODE_ID_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration port
  input  wire logic                             cfg_we,
  input  wire logic [ftnh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ftnh_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [ftnh_pkg::OP_W-1:0]        in_op,
  input  wire logic [ftnh_pkg::IDX_W-1:0]       in_entry_index,
  input  wire logic [NODE_ID_BITS-1:0]          in_node_id,
  input  wire logic [ftnh_pkg::OCTET_W-1:0]     in_octet_a,
  input  wire logic [ftnh_pkg::OCTET_W-1:0]     in_octet_b,
  input  wire logic [ftnh_pkg::OCTET_W-1:0]     in_octet_c,
  input  wire logic [ftnh_pkg::OCTET_W-1:0]     in_octet_d,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_found,
  output logic [ftnh_pkg::OUT_NODE_W-1:0]       out_next_node,
  output logic [ftnh_pkg::OUT_PORT_W-1:0]       out_out_port
);

  import ftnh_pkg::*;

  localparam int HALF    = PORTS / 2;
  localparam int PIDX_W  = $clog2(PORTS);
  localparam int NBR_W   = PORTS * NODE_ID_BITS;
  localparam int CORE_W  = PORTS * (2 * OCTET_W + NODE_ID_BITS);
  localparam int PFX_W   = HALF * (3 * OCTET_W + NODE_ID_BITS);
  localparam int SFX_W   = HALF * (OCTET_W + NODE_ID_BITS);
  // no row is wider than the core row (the prefix+suffix row ties it when PORTS is even)
  localparam int ROW_BITS = CORE_W;
  localparam int ROWS     = 3;

  localparam logic [1:0] ROW_NBR  = 2'd0;
  localparam logic [1:0] ROW_CORE = 2'd1;
  localparam logic [1:0] ROW_PS   = 2'd2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_MATCH = 2'd2;
  localparam logic [1:0] ST_PORT  = 2'd3;

  typedef logic [NODE_ID_BITS-1:0] node_t;

  typedef struct packed {
    logic [OCTET_W-1:0] a;
    logic [OCTET_W-1:0] b;
    node_t              hop;
  } core_ent_t;

  typedef struct packed {
    logic [OCTET_W-1:0] a;
    logic [OCTET_W-1:0] b;
    logic [OCTET_W-1:0] c;
    node_t              hop;
  } pfx_ent_t;

  typedef struct packed {
    logic [OCTET_W-1:0] d;
    node_t              hop;
  } sfx_ent_t;

  // configuration
  logic [ROLE_W-1:0]     node_role_r;
  logic [OUT_NODE_W-1:0] uplink_r;

  // control
  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       in_accept;
  logic       out_free;

  // captured word
  logic [OP_W-1:0]    op_r;
  logic [IDX_W-1:0]   idx_r;
  node_t              node_r;
  logic [OCTET_W-1:0] oct_a_r;
  logic [OCTET_W-1:0] oct_b_r;
  logic [OCTET_W-1:0] oct_c_r;
  logic [OCTET_W-1:0] oct_d_r;

  // table memory
  logic [ROW_BITS-1:0] mem_r [ROWS];
  logic [1:0]          rd_row;
  logic [1:0]          wr_row_r;
  logic [NBR_W-1:0]    rd_a_r;
  logic [ROW_BITS-1:0] rd_b_r;
  logic [ROW_BITS-1:0] row_nxt;

  // unpacked views of the read rows
  node_t     [PORTS-1:0] nbr_rd;
  core_ent_t [PORTS-1:0] core_rd;
  pfx_ent_t  [HALF-1:0]  pfx_rd;
  sfx_ent_t  [HALF-1:0]  sfx_rd;

  // write-back copies
  node_t     [PORTS-1:0] nbr_mod;
  core_ent_t [PORTS-1:0] core_mod;
  pfx_ent_t  [HALF-1:0]  pfx_mod;
  sfx_ent_t  [HALF-1:0]  sfx_mod;

  // match stage
  logic              dir_hit;
  logic [PIDX_W-1:0] dir_port;
  logic              rt_hit;
  node_t             rt_hop;
  logic              m_host;
  logic              m_found;
  logic [OUT_NODE_W-1:0] m_node;
  logic [OUT_PORT_W-1:0] m_port;

  logic                  found_r;
  logic [OUT_NODE_W-1:0] res_node_r;
  logic [OUT_PORT_W-1:0] res_port_r;
  logic                  search_r;
  node_t                 hop_r;

  // port search stage
  logic [PIDX_W-1:0]     srch_port;
  logic [OUT_PORT_W-1:0] fin_port;

  // output register
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [OUT_NODE_W-1:0] out_node_r;
  logic [OUT_PORT_W-1:0] out_port_r;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) || ((state_r == ST_PORT) && out_free);
  assign in_accept = in_valid && in_ready;

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_next_node = out_node_r;
  assign out_out_port  = out_port_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_role_r <= ROLE_HOST;
      uplink_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_ROLE: node_role_r <= cfg_wdata[ROLE_W-1:0];
        REG_UPLINK:    uplink_r    <= cfg_wdata;
      endcase
    end
  end

  // row read with the word: its own table for a load, the role's route row for a lookup
  always_comb begin
    unique case (in_op)
      OP_WR_NBR:  rd_row = ROW_NBR;
      OP_WR_CORE: rd_row = ROW_CORE;
      OP_WR_PFX,
      OP_WR_SFX:  rd_row = ROW_PS;
      default:    rd_row = (node_role_r == ROLE_CORE) ? ROW_CORE : ROW_PS;
    endcase
  end

  // no word is accepted during write-back, so reads never race the write
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_a_r   <= mem_r[ROW_NBR][NBR_W-1:0];
      rd_b_r   <= mem_r[rd_row];
      wr_row_r <= rd_row;
      op_r     <= in_op;
      idx_r    <= in_entry_index;
      node_r   <= in_node_id;
      oct_a_r  <= in_octet_a;
      oct_b_r  <= in_octet_b;
      oct_c_r  <= in_octet_c;
      oct_d_r  <= in_octet_d;
    end
    if (state_r == ST_WRITE) begin
      mem_r[wr_row_r] <= row_nxt;
    end
  end

  assign nbr_rd  = rd_a_r;
  assign core_rd = rd_b_r;
  assign pfx_rd  = rd_b_r[PFX_W-1:0];
  assign sfx_rd  = rd_b_r[PFX_W +: SFX_W];

  // modify one entry of the row read for a load; an index beyond the table drops the write
  always_comb begin
    nbr_mod  = rd_b_r[NBR_W-1:0];
    core_mod = rd_b_r;
    pfx_mod  = rd_b_r[PFX_W-1:0];
    sfx_mod  = rd_b_r[PFX_W +: SFX_W];
    for (int i = 0; i < PORTS; i++) begin
      if (i == int'(idx_r)) begin
        nbr_mod[i]  = node_r;
        core_mod[i] = '{a: oct_a_r, b: oct_b_r, hop: node_r};
      end
    end
    for (int i = 0; i < HALF; i++) begin
      if (i == int'(idx_r)) begin
        pfx_mod[i] = '{a: oct_a_r, b: oct_b_r, c: oct_c_r, hop: node_r};
        sfx_mod[i] = '{d: oct_d_r, hop: node_r};
      end
    end
    row_nxt = rd_b_r;
    unique case (op_r)
      OP_WR_NBR:  row_nxt[NBR_W-1:0] = nbr_mod;
      OP_WR_CORE: row_nxt = core_mod;
      OP_WR_PFX:  row_nxt[PFX_W-1:0] = pfx_mod;
      OP_WR_SFX:  row_nxt[PFX_W +: SFX_W] = sfx_mod;
      default:    row_nxt = rd_b_r;
    endcase
  end

  // match: a host answers with its uplink; else direct neighbor first, then the role's route tables, lowest entry wins
  always_comb begin
    dir_hit  = 1'b0;
    dir_port = '0;
    for (int i = PORTS - 1; i >= 0; i--) begin
      if (nbr_rd[i] == node_r) begin
        dir_hit  = 1'b1;
        dir_port = PIDX_W'(i);
      end
    end
    rt_hit = 1'b0;
    rt_hop = '0;
    unique case (node_role_r)
      ROLE_HOST: begin
        rt_hit = 1'b0;
      end
      ROLE_CORE: begin
        for (int i = PORTS - 1; i >= 0; i--) begin
          if (core_rd[i].a == oct_a_r && core_rd[i].b == oct_b_r) begin
            rt_hit = 1'b1;
            rt_hop = core_rd[i].hop;
          end
        end
      end
      ROLE_EDGE: begin
        for (int i = HALF - 1; i >= 0; i--) begin
          if (sfx_rd[i].d == oct_d_r) begin
            rt_hit = 1'b1;
            rt_hop = sfx_rd[i].hop;
          end
        end
      end
      ROLE_AGG: begin
        // suffix first so that any prefix hit overrides it
        for (int i = HALF - 1; i >= 0; i--) begin
          if (sfx_rd[i].d == oct_d_r) begin
            rt_hit = 1'b1;
            rt_hop = sfx_rd[i].hop;
          end
        end
        for (int i = HALF - 1; i >= 0; i--) begin
          if (pfx_rd[i].a == oct_a_r && pfx_rd[i].b == oct_b_r && pfx_rd[i].c == oct_c_r) begin
            rt_hit = 1'b1;
            rt_hop = pfx_rd[i].hop;
          end
        end
      end
    endcase

    m_host  = (node_role_r == ROLE_HOST);
    m_found = m_host || dir_hit || rt_hit;
    if (m_host) begin
      m_node = uplink_r;
    end else if (dir_hit) begin
      m_node = OUT_NODE_W'(node_r);
    end else if (rt_hit) begin
      m_node = OUT_NODE_W'(rt_hop);
    end else begin
      m_node = '0;
    end
    m_port = (!m_host && dir_hit) ? OUT_PORT_W'(dir_port) : '0;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MATCH) begin
      found_r    <= m_found;
      res_node_r <= m_node;
      res_port_r <= m_port;
      search_r   <= !m_host && !dir_hit && rt_hit;
      hop_r      <= rt_hop;
    end
  end

  // port search: first port whose neighbor is the routed next hop, port 0 if none
  always_comb begin
    srch_port = '0;
    for (int i = PORTS - 1; i >= 0; i--) begin
      if (nbr_rd[i] == hop_r) begin
        srch_port = PIDX_W'(i);
      end
    end
    fin_port = search_r ? OUT_PORT_W'(srch_port) : res_port_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE,
      ST_PORT: begin
        if (state_r == ST_PORT && out_free) begin
          state_nxt = ST_IDLE;
        end
        if (in_accept) begin
          unique case (in_op)
            OP_LOOKUP:  state_nxt = ST_MATCH;
            OP_WR_NBR,
            OP_WR_CORE,
            OP_WR_PFX,
            OP_WR_SFX:  state_nxt = ST_WRITE;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: state_nxt = ST_IDLE;
      ST_MATCH: state_nxt = ST_PORT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_PORT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (state_r == ST_PORT && out_free) begin
      out_found_r <= found_r;
      out_node_r  <= res_node_r;
      out_port_r  <= fin_port;
    end
  end

endmodule

`default_nettype wire
